// ===== rtl/slfr_pkg.sv =====
// Package for the sync/length frame receiver: payload types and constants.
package slfr_pkg;

  localparam int BUF_DEPTH    = 64;
  localparam int IDX_W        = $clog2(BUF_DEPTH);
  localparam int COUNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int HEADER_SLACK = 5;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] MAX_LENGTH  = 8'(BUF_DEPTH - HEADER_SLACK);

  localparam logic [IDX_W-1:0] POS_HUNT    = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_SYNC2   = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_COMMAND = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_LENGTH  = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_DATA    = IDX_W'(4);

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_REARM = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       frame_error;
  } item_t;

  typedef struct packed {
    logic               write_valid;
    logic [IDX_W-1:0]   write_index;
    logic [7:0]         write_byte;
    logic               frame_done;
    logic [COUNT_W-1:0] frame_bytes;
    logic               length_rejected;
    logic               receiver_locked;
  } result_t;

endpackage

// ===== rtl/slfr_core.sv =====
// Deframer state and per-byte decode: sync hunt, header, data count, lock.
module slfr_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  slfr_pkg::item_t item,
  output slfr_pkg::result_t result
);
  import slfr_pkg::*;

  logic [IDX_W-1:0] position, position_next;
  logic [IDX_W-1:0] end_index, end_index_next;
  logic             locked, locked_next;

  always_comb begin
    position_next   = position;
    end_index_next  = end_index;
    locked_next     = locked;
    result          = '0;

    if (item.op == OP_REARM) begin
      locked_next = 1'b0;
    end else if (!locked) begin
      if (item.frame_error) begin
        position_next = POS_HUNT;
      end else begin
        unique case (position)
          POS_HUNT: begin
            if (item.rx_byte == SYNC_FIRST) position_next = POS_SYNC2;
          end
          POS_SYNC2: begin
            // a mismatch restarts the hunt without re-examining this byte
            position_next = (item.rx_byte == SYNC_SECOND) ? POS_COMMAND : POS_HUNT;
          end
          POS_COMMAND: begin
            result.write_valid = 1'b1;
            result.write_index = POS_COMMAND;
            result.write_byte  = item.rx_byte;
            position_next      = POS_LENGTH;
          end
          POS_LENGTH: begin
            result.write_valid = 1'b1;
            result.write_index = POS_LENGTH;
            result.write_byte  = item.rx_byte;
            if (item.rx_byte > MAX_LENGTH) begin
              result.length_rejected = 1'b1;
              position_next          = POS_HUNT;
            end else begin
              end_index_next = POS_DATA + item.rx_byte[IDX_W-1:0];
              position_next  = POS_DATA;
            end
          end
          default: begin
            result.write_valid = 1'b1;
            result.write_index = position;
            result.write_byte  = item.rx_byte;
            if (position >= end_index) begin
              result.frame_done  = 1'b1;
              result.frame_bytes = COUNT_W'(end_index) + COUNT_W'(1);
              position_next      = POS_HUNT;
              locked_next        = 1'b1;
            end else begin
              position_next = position + IDX_W'(1);
            end
          end
        endcase
      end
    end

    result.receiver_locked = locked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= POS_HUNT;
      end_index <= '0;
      locked    <= 1'b0;
    end else if (accept) begin
      position  <= position_next;
      end_index <= end_index_next;
      locked    <= locked_next;
    end
  end

endmodule

// ===== rtl/slfr_skid.sv =====
// Two-entry output buffer: result register plus skid register.
module slfr_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  slfr_pkg::result_t load_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output slfr_pkg::result_t result
);
  import slfr_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    drain;

  assign drain        = main_valid && !result_stall;
  assign full         = skid_valid;
  assign result_valid = main_valid;
  assign result       = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // advance the held result once the head drains
        if (drain) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (load) begin
        if (main_valid && !drain) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end else if (drain) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) main_data <= skid_data;
    end else if (load) begin
      if (main_valid && !drain) begin
        skid_data <= load_data;
      end else begin
        main_data <= load_data;
      end
    end
  end

endmodule

// ===== rtl/sync_length_frame_receiver.sv =====
// Sync-word, length-prefixed frame receiver: top level.
// Hunts for the pair 0x55, 0xAA in the received byte stream, then stores the
// command byte at buffer index 2, the length byte L at index 3 and L+1 data
// bytes at indices 4 to 4+L, one write report per input transfer. A length
// above the buffer limit drops the frame; a framing error restarts the hunt.
// After a complete frame the receiver locks until a rearm item. Every input
// transfer yields exactly one result transfer, held in a register. An item is
// taken every cycle while input stall is low; the decode is a single stage
// of compares on the position register. A two-entry output buffer
// (result register plus skid register) keeps input stall a registered
// signal: it rises only after two results are held back by output stall.
module sync_length_frame_receiver (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  slfr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output slfr_pkg::result_t result
);
  import slfr_pkg::*;

  logic    accept;
  logic    buffer_full;
  result_t decoded;

  assign item_stall = buffer_full;
  assign accept     = item_valid && !buffer_full;

  slfr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (decoded)
  );

  slfr_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .load_data    (decoded),
    .full         (buffer_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
